@@ design/htlp_pkg.sv @@
// ----------------------------------------------------------------------------
// htlp_pkg
// shared constants for the linear probing hash table
// ----------------------------------------------------------------------------
package htlp_pkg;

    localparam int unsigned SLOTS_DEFAULT = 1024;

    localparam int unsigned SIZE_W = 11;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    localparam int unsigned KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
    // no operation, reports not found
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int unsigned STATUS_W = 3;
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd5;

    localparam int unsigned MARK_W = 2;
    localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
    localparam logic [MARK_W-1:0] MARK_LIVE    = 2'd1;
    localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

    localparam int unsigned DATA_W = 32;
    // entry layout: value low, key, mark high
    localparam int unsigned ENTRY_W = MARK_W + 2 * DATA_W;

    localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;

endpackage

@@ design/hash_table_linear_probe.sv @@
// ----------------------------------------------------------------------------
// hash_table_linear_probe
// key/value table, open addressing, fnv-1a 64 home slot, linear probing
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tuser: kind[1:0]; tdata: key[31:0], value[63:32]
//  m_axis    out        tuser: status[2:0]; tdata: found_value[31:0]
//  cfg       in         cfg_data: size[10:0]
//
//  an item is hashed, reduced by a bit-serial remainder to its home slot,
//  then walks the probe sequence one slot at a time, and ends with an
//  optional write-back and the result.
//  after reset a clearing pass marks every slot empty; no item is taken
//  then. a result waits in the output register while the next item is
//  taken; finishing the next one stalls until it is taken.
// ----------------------------------------------------------------------------
module hash_table_linear_probe #(
    parameter int unsigned SLOTS = htlp_pkg::SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key[31:0], value[63:32]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // found_value[31:0]
    output logic [2:0]  m_tuser,   // status[2:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data
);

    localparam int unsigned AW = $clog2(SLOTS);
    localparam int unsigned NW = $clog2(SLOTS + 1);
    localparam int unsigned EW = htlp_pkg::ENTRY_W;
    localparam int unsigned DW = htlp_pkg::DATA_W;

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HOME  = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_WR    = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [10:0] size_reg;
    logic [AW-1:0] clr_reg, clr_next;

    logic [1:0]    kind_reg, kind_next;
    logic [31:0]   key_reg, key_next;
    logic [31:0]   val_reg, val_next;
    logic [NW-1:0] n_reg, n_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [NW-1:0] steps_reg, steps_next;
    logic          free_v_reg, free_v_next;
    logic [AW-1:0] free_reg, free_next;
    logic [AW-1:0] wa_reg, wa_next;
    logic [EW-1:0] wd_reg, wd_next;
    logic [2:0]    res_st_reg, res_st_next;
    logic [31:0]   res_fv_reg, res_fv_next;

    logic        out_v_reg, out_v_next;
    logic [2:0]  out_st_reg, out_st_next;
    logic [31:0] out_fv_reg, out_fv_next;

    logic [31:0]   size32, n32;
    logic [NW-1:0] n_eff;

    logic          ram_we;
    logic [AW-1:0] ram_wa, ram_ra;
    logic [EW-1:0] ram_wd, ram_rd;
    logic          home_start, home_done;
    logic [AW-1:0] home_slot;

    logic [1:0]    rd_mark;
    logic [31:0]   rd_key, rd_val;
    logic [AW-1:0] idx_inc;
    logic          accept;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    assign size32 = {21'd0, size_reg};
    always_comb
    begin
        if (size32 == 32'd0)
        begin
            n32 = 32'd1;
        end
        else if (size32 > SLOTS)
        begin
            n32 = SLOTS;
        end
        else
        begin
            n32 = size32;
        end
    end
    assign n_eff = n32[NW-1:0];

    assign rd_mark = ram_rd[EW-1 -: htlp_pkg::MARK_W];
    assign rd_key  = ram_rd[2*DW-1:DW];
    assign rd_val  = ram_rd[DW-1:0];
    assign idx_inc = ((32'(idx_reg) + 32'd1) == 32'(n_reg)) ? '0 : AW'(32'(idx_reg) + 32'd1);

    assign home_start = accept && (s_tuser != htlp_pkg::KIND_UNUSED);

    htlp_home #(
        .SLOTS(SLOTS)
    ) u_home (
        .clk  (clk),
        .rst_n(rst_n),
        .start(home_start),
        .key  (s_tdata[31:0]),
        .n    (n_eff),
        .done (home_done),
        .slot (home_slot)
    );

    htlp_ram #(
        .WIDTH(EW),
        .DEPTH(SLOTS)
    ) u_ram (
        .clk    (clk),
        .we     (ram_we),
        .wr_addr(ram_wa),
        .wr_data(ram_wd),
        .rd_addr(ram_ra),
        .rd_data(ram_rd)
    );

    assign ram_ra = (state_reg == S_HOME) ? home_slot : idx_inc;

    always_comb
    begin
        ram_we = 1'b0;
        ram_wa = wa_reg;
        ram_wd = wd_reg;
        if (state_reg == S_CLR)
        begin
            ram_we = 1'b1;
            ram_wa = clr_reg;
            ram_wd = '0;
        end
        else if (state_reg == S_WR)
        begin
            ram_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        kind_next   = kind_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        steps_next  = steps_reg;
        free_v_next = free_v_reg;
        free_next   = free_reg;
        wa_next     = wa_reg;
        wd_next     = wd_reg;
        res_st_next = res_st_reg;
        res_fv_next = res_fv_reg;
        out_v_next  = out_v_reg && !m_tready;
        out_st_next = out_st_reg;
        out_fv_next = out_fv_reg;
        case (state_reg)
            S_CLR:
            begin
                clr_next = clr_reg + AW'(1);
                if (32'(clr_reg) == SLOTS - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next   = s_tuser;
                    key_next    = s_tdata[31:0];
                    val_next    = s_tdata[63:32];
                    n_next      = n_eff;
                    res_st_next = htlp_pkg::ST_NOT_FOUND;
                    res_fv_next = '0;
                    state_next  = (s_tuser == htlp_pkg::KIND_UNUSED) ? S_OUT : S_HOME;
                end
            end
            S_HOME:
            begin
                if (home_done)
                begin
                    idx_next    = home_slot;
                    steps_next  = '0;
                    free_v_next = 1'b0;
                    state_next  = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (rd_mark == htlp_pkg::MARK_LIVE && rd_key == key_reg)
                begin
                    wa_next = idx_reg;
                    case (kind_reg)
                        htlp_pkg::KIND_INSERT:
                        begin
                            wd_next     = {htlp_pkg::MARK_LIVE, key_reg, val_reg};
                            res_st_next = htlp_pkg::ST_UPDATED;
                            state_next  = S_WR;
                        end
                        htlp_pkg::KIND_LOOKUP:
                        begin
                            res_st_next = htlp_pkg::ST_FOUND;
                            res_fv_next = rd_val;
                            state_next  = S_OUT;
                        end
                        default:
                        begin
                            wd_next     = {htlp_pkg::MARK_DELETED, rd_key, rd_val};
                            res_st_next = htlp_pkg::ST_DELETED;
                            state_next  = S_WR;
                        end
                    endcase
                end
                else
                begin
                    if (!free_v_reg && rd_mark != htlp_pkg::MARK_LIVE)
                    begin
                        free_v_next = 1'b1;
                        free_next   = idx_reg;
                    end
                    if (rd_mark == htlp_pkg::MARK_EMPTY || 32'(steps_reg) + 32'd1 == 32'(n_reg))
                    begin
                        // walk ends without a match
                        if (kind_reg == htlp_pkg::KIND_INSERT)
                        begin
                            if (free_v_next)
                            begin
                                wa_next     = free_next;
                                wd_next     = {htlp_pkg::MARK_LIVE, key_reg, val_reg};
                                res_st_next = htlp_pkg::ST_INSERTED;
                                state_next  = S_WR;
                            end
                            else
                            begin
                                res_st_next = htlp_pkg::ST_FULL;
                                state_next  = S_OUT;
                            end
                        end
                        else
                        begin
                            state_next = S_OUT;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        steps_next = steps_reg + NW'(1);
                    end
                end
            end
            S_WR:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_v_reg || m_tready)
                begin
                    out_v_next  = 1'b1;
                    out_st_next = res_st_reg;
                    out_fv_next = res_fv_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            size_reg  <= htlp_pkg::SIZE_RESET;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            out_v_reg <= out_v_next;
            if (cfg_valid && cfg_ready)
            begin
                size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        n_reg      <= n_next;
        idx_reg    <= idx_next;
        steps_reg  <= steps_next;
        free_v_reg <= free_v_next;
        free_reg   <= free_next;
        wa_reg     <= wa_next;
        wd_reg     <= wd_next;
        res_st_reg <= res_st_next;
        res_fv_reg <= res_fv_next;
        out_st_reg <= out_st_next;
        out_fv_reg <= out_fv_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tuser  = out_st_reg;
    assign m_tdata  = out_fv_reg;

    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !s_tready)
        else $error("item taken during clearing pass");

    a_no_write_in_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> !ram_we)
        else $error("table written during probe walk");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("idle right after taking an item");

    a_home_in_time: assert property (@(posedge clk) disable iff (!rst_n)
        home_done |-> (state_reg == S_HOME))
        else $error("home slot ready outside hashing");

endmodule

@@ design/htlp_ram.sv @@
// ----------------------------------------------------------------------------
// htlp_ram
// generic simple dual-port ram with registered read
// ----------------------------------------------------------------------------
module htlp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ design/htlp_home.sv @@
// ----------------------------------------------------------------------------
// htlp_home
// fnv-1a 64 hash of the key, one byte per cycle, then a bit-serial
// remainder by the table size to give the home slot
// ----------------------------------------------------------------------------
module htlp_home #(
    parameter int unsigned SLOTS = htlp_pkg::SLOTS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [31:0]                key,
    input  logic [$clog2(SLOTS+1)-1:0] n,
    output logic                       done,
    output logic [$clog2(SLOTS)-1:0]   slot
);

    localparam int unsigned AW = $clog2(SLOTS);
    localparam int unsigned NW = $clog2(SLOTS + 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HASH = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;

    logic [1:0]    phase_reg, phase_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [63:0]   h_reg, h_next;
    logic [31:0]   k_reg, k_next;
    logic [NW-1:0] r_reg, r_next;
    logic          done_reg, done_next;

    logic [63:0] hx;
    logic [63:0] hmul;
    logic [NW:0] rsh;

    assign hx   = h_reg ^ {56'd0, k_reg[7:0]};
    // multiply by 0x100000001b3 as a sum of shifts
    assign hmul = hx + (hx << 1) + (hx << 4) + (hx << 5) + (hx << 7) + (hx << 8)
                + (hx << 40);
    assign rsh  = {r_reg, h_reg[63]};

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        h_next     = h_reg;
        k_next     = k_reg;
        r_next     = r_reg;
        done_next  = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    phase_next = PH_HASH;
                    cnt_next   = 6'd0;
                    h_next     = htlp_pkg::FNV_OFFSET;
                    k_next     = key;
                end
            end
            PH_HASH:
            begin
                h_next   = hmul;
                k_next   = {8'd0, k_reg[31:8]};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd3)
                begin
                    phase_next = PH_DIV;
                    cnt_next   = 6'd0;
                    r_next     = '0;
                end
            end
            PH_DIV:
            begin
                h_next   = {h_reg[62:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (rsh >= {1'b0, n})
                begin
                    r_next = NW'(rsh - {1'b0, n});
                end
                else
                begin
                    r_next = rsh[NW-1:0];
                end
                if (cnt_reg == 6'd63)
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        k_reg <= k_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign slot = r_reg[AW-1:0];

endmodule

@@ bench/tb_hash_table_linear_probe.sv @@
// ----------------------------------------------------------------------------
// tb_hash_table_linear_probe
// self-checking bench for the linear probing hash table
// ----------------------------------------------------------------------------
// a shadow table predicts the status and found value of every accepted
// operation. directed cases hit the field extremes, updates, full tables,
// deleted slot reuse and the unused kind. random phases then run over a
// range of table sizes, with random idling on both sides and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb_hash_table_linear_probe;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TABLE_SLOTS = htlp_pkg::SLOTS_DEFAULT;
    localparam int unsigned IDLE_LIMIT = 8000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned PHASE_ITEMS = 116;

    typedef struct {
        logic [htlp_pkg::STATUS_W-1:0] status;
        logic [31:0]                   found_value;
    } table_reply_t;

    class table_scoreboard;
        logic [31:0]                 slot_key [TABLE_SLOTS];
        logic [31:0]                 slot_value [TABLE_SLOTS];
        logic [htlp_pkg::MARK_W-1:0] slot_mark [TABLE_SLOTS];
        logic [10:0]                 size_cfg;
        table_reply_t                pending_replies [$];
        int                          errors;

        function new();
            foreach (slot_mark[i])
            begin
                slot_mark[i] = htlp_pkg::MARK_EMPTY;
                slot_key[i] = '0;
                slot_value[i] = '0;
            end
            size_cfg = htlp_pkg::SIZE_RESET;
            errors = 0;
        endfunction

        function void set_size(logic [10:0] n);
            size_cfg = n;
        endfunction

        function void note_op(logic [htlp_pkg::KIND_W-1:0] kind, logic [31:0] key,
                              logic [31:0] value);
            int unsigned  n;
            int unsigned  idx;
            int           hit;
            int           free_at;
            bit           done;
            logic [63:0]  h;
            table_reply_t r;
            n = size_cfg;
            if (n == 0)
                n = 1;
            if (n > TABLE_SLOTS)
                n = TABLE_SLOTS;
            h = htlp_pkg::FNV_OFFSET;
            for (int i = 0; i < 4; i++)
            begin
                h = h ^ {56'd0, key[8*i +: 8]};
                h = h * 64'h100000001b3;
            end
            idx = int'(h % 64'(n));
            hit = -1;
            free_at = -1;
            done = 0;
            for (int s = 0; s < n && !done; s++)
            begin
                if (slot_mark[idx] == htlp_pkg::MARK_EMPTY)
                begin
                    if (free_at < 0)
                        free_at = int'(idx);
                    done = 1;
                end
                else if (slot_mark[idx] == htlp_pkg::MARK_LIVE)
                begin
                    if (slot_key[idx] == key)
                    begin
                        hit = int'(idx);
                        done = 1;
                    end
                end
                else if (free_at < 0)
                    free_at = int'(idx);
                if (!done)
                    idx = (idx + 1 >= n) ? 0 : idx + 1;
            end
            r.status = htlp_pkg::ST_NOT_FOUND;
            r.found_value = '0;
            if (kind == htlp_pkg::KIND_INSERT)
            begin
                if (hit >= 0)
                begin
                    slot_value[hit] = value;
                    r.status = htlp_pkg::ST_UPDATED;
                end
                else if (free_at >= 0)
                begin
                    slot_key[free_at] = key;
                    slot_value[free_at] = value;
                    slot_mark[free_at] = htlp_pkg::MARK_LIVE;
                    r.status = htlp_pkg::ST_INSERTED;
                end
                else
                    r.status = htlp_pkg::ST_FULL;
            end
            else if (kind == htlp_pkg::KIND_LOOKUP)
            begin
                if (hit >= 0)
                begin
                    r.status = htlp_pkg::ST_FOUND;
                    r.found_value = slot_value[hit];
                end
            end
            else if (kind == htlp_pkg::KIND_DELETE)
            begin
                if (hit >= 0)
                begin
                    slot_mark[hit] = htlp_pkg::MARK_DELETED;
                    r.status = htlp_pkg::ST_DELETED;
                end
            end
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic [htlp_pkg::STATUS_W-1:0] status, logic [31:0] fv);
            table_reply_t r;
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected result status %0d value %h", $time, status, fv);
                errors++;
                return;
            end
            r = pending_replies.pop_front();
            if (status !== r.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, r.status, status);
                errors++;
            end
            if (fv !== r.found_value)
            begin
                $display("%0t: found_value expected %h actual %h",
                         $time, r.found_value, fv);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [10:0] cfg_data;

    table_scoreboard sb;
    bit          quiet;
    bit          no_gaps;
    bit          hold_req;
    int unsigned idle_cycles;
    logic [31:0] key_pool [20];

    hash_table_linear_probe DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        quiet = 0;
        no_gaps = 0;
        hold_req = 0;
        idle_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_reply(m_tuser, m_tdata);
            if (hold_req)
            begin
                hold_req = 0;
                stall_left = HOLD_CYCLES;
            end
            else if (quiet)
                stall_left = 0;
            else if (stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 9);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_op(logic [htlp_pkg::KIND_W-1:0] kind, logic [31:0] key,
                           logic [31:0] value);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {value, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_op(kind, key, value);
        if (!quiet && !no_gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_size(logic [10:0] n);
        cfg_valid <= 1'b1;
        cfg_data <= n;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_size(n);
        @(posedge clk);
    endtask

    task automatic random_phase(logic [10:0] n, int unsigned items);
        logic [htlp_pkg::KIND_W-1:0] kind;
        logic [31:0]                 key;
        int unsigned                 pick;
        write_size(n);
        for (int i = 0; i < items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                kind = htlp_pkg::KIND_INSERT;
            else if (pick < 70)
                kind = htlp_pkg::KIND_LOOKUP;
            else if (pick < 95)
                kind = htlp_pkg::KIND_DELETE;
            else
                kind = htlp_pkg::KIND_UNUSED;
            key = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, 19)] : $urandom;
            send_op(kind, key, $urandom);
        end
        drain();
    endtask

    initial
    begin
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hffff_ffff;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7fff_ffff;
        @(posedge rst_n);
        @(posedge clk);

        // directed cases on the full table
        write_size(11'd1024);
        send_op(htlp_pkg::KIND_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_op(htlp_pkg::KIND_INSERT, 32'h7fff_ffff, 32'h8000_0000);
        send_op(htlp_pkg::KIND_INSERT, 32'h8000_0000, 32'hffff_ffff);
        send_op(htlp_pkg::KIND_INSERT, 32'hffff_ffff, 32'h7fff_ffff);
        send_op(htlp_pkg::KIND_INSERT, 32'h7fff_ffff, 32'h1234_5678);
        send_op(htlp_pkg::KIND_LOOKUP, 32'h7fff_ffff, 32'h0);
        send_op(htlp_pkg::KIND_LOOKUP, 32'h8000_0000, 32'hffff_ffff);
        send_op(htlp_pkg::KIND_LOOKUP, 32'h0000_0001, 32'h0);
        send_op(htlp_pkg::KIND_DELETE, 32'hffff_ffff, 32'h0);
        send_op(htlp_pkg::KIND_DELETE, 32'hffff_ffff, 32'h0);
        send_op(htlp_pkg::KIND_LOOKUP, 32'hffff_ffff, 32'h0);
        send_op(htlp_pkg::KIND_UNUSED, 32'h0000_0000, 32'hffff_ffff);
        send_op(htlp_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h0);
        drain();

        // two slots: fill, overflow, reuse a deleted slot
        write_size(11'd2);
        send_op(htlp_pkg::KIND_INSERT, 32'h0000_0011, 32'haaaa_5555);
        send_op(htlp_pkg::KIND_INSERT, 32'h0000_0022, 32'h5555_aaaa);
        send_op(htlp_pkg::KIND_INSERT, 32'h0000_0033, 32'h0000_0001);
        send_op(htlp_pkg::KIND_DELETE, 32'h0000_0011, 32'h0);
        send_op(htlp_pkg::KIND_LOOKUP, 32'h0000_0022, 32'h0);
        send_op(htlp_pkg::KIND_INSERT, 32'h0000_0033, 32'h0000_0002);
        send_op(htlp_pkg::KIND_LOOKUP, 32'h0000_0033, 32'h0);
        drain();

        // zero size acts as one slot
        write_size(11'd0);
        send_op(htlp_pkg::KIND_INSERT, 32'hdead_beef, 32'hcafe_f00d);
        send_op(htlp_pkg::KIND_INSERT, 32'h0bad_f00d, 32'h1);
        send_op(htlp_pkg::KIND_LOOKUP, 32'hdead_beef, 32'h0);
        drain();

        random_phase(11'd3, PHASE_ITEMS);
        hold_req = 1;
        no_gaps = 1;
        random_phase(11'd16, PHASE_ITEMS);
        no_gaps = 0;
        random_phase(11'd1024, PHASE_ITEMS);
        random_phase(11'd0, PHASE_ITEMS);
        random_phase(11'd2047, PHASE_ITEMS);
        random_phase(11'd5, PHASE_ITEMS);
        random_phase(11'd64, PHASE_ITEMS);
        quiet = 1;
        random_phase(11'd1, PHASE_ITEMS / 2);
        random_phase(11'd9, PHASE_ITEMS / 2);
        repeat (20) @(posedge clk);

        if (sb.errors == 0 && sb.pending_replies.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
